// ----- rtl/apwa_pkg.sv -----
// Shared types and register codes for the AC period window accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package apwa_pkg;

  localparam int HYST_BITS   = 9;
  localparam int SHIFT_BITS  = 4;
  localparam int PERIOD_BITS = 8;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [1:0] {
    CFG_BIAS_RATE  = 2'd0,
    CFG_HYSTERESIS = 2'd1,
    CFG_PERIODS    = 2'd2
  } cfg_reg_e;

  // crossing status handed from the bias tracker to the window accumulator
  typedef struct packed {
    logic armed;
    logic rising;
  } xing_t;

endpackage

`default_nettype wire

// ----- rtl/apwa_bias_tracker.sv -----
// Bias low-pass filter (Q8), hysteretic rising-crossing detector and arm flag.
// Depends on apwa_pkg.
`default_nettype none

module apwa_bias_tracker import apwa_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [SHIFT_BITS-1:0]  bias_rate,
  input  wire logic [HYST_BITS-1:0]   hysteresis,
  output xing_t                       xing
);

  localparam int BW = SAMPLE_BITS + 8;
  localparam int CW = ((SAMPLE_BITS > HYST_BITS) ? SAMPLE_BITS : HYST_BITS) + 2;
  localparam logic [BW-1:0] BIAS_RESET = {1'b1, {(BW-1){1'b0}}};

  logic [BW-1:0]        bias_q8;
  logic [BW-1:0]        bias_q8_next;
  logic                 last_below;
  logic                 last_below_next;
  logic                 seen;
  logic                 armed;
  logic signed [BW:0]   diff;
  logic signed [BW:0]   delta;
  logic signed [BW:0]   bias_sum;
  logic signed [CW-1:0] centered;
  logic signed [CW-1:0] hyst_s;
  logic                 below;
  logic                 above;
  logic                 rising;

  always_comb begin
    diff         = $signed({1'b0, sample, 8'b0}) - $signed({1'b0, bias_q8});
    delta        = diff >>> bias_rate;
    bias_sum     = $signed({1'b0, bias_q8}) + delta;
    bias_q8_next = bias_sum[BW-1:0];
    centered     = $signed(CW'(sample)) - $signed(CW'(bias_q8_next[BW-1:8]));
    hyst_s       = $signed(CW'(hysteresis));
    below        = centered <= -hyst_s;
    above        = centered >= hyst_s;
    rising       = seen && last_below && above;
    if (!armed && rising) begin
      last_below_next = 1'b0;
    end else if (below) begin
      last_below_next = 1'b1;
    end else if (above) begin
      last_below_next = 1'b0;
    end else begin
      last_below_next = last_below;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_q8    <= BIAS_RESET;
      last_below <= 1'b0;
      seen       <= 1'b0;
      armed      <= 1'b0;
    end else if (step) begin
      bias_q8    <= bias_q8_next;
      last_below <= last_below_next;
      seen       <= 1'b1;
      armed      <= armed | rising;
    end
  end

  assign xing.armed  = armed;
  assign xing.rising = rising;

endmodule

`default_nettype wire

// ----- rtl/apwa_window_acc.sv -----
// Window accumulators: sum, sum of squares, min, max, count, period counter.
// Depends on apwa_pkg; produces the closing record for the output register.
`default_nettype none

module apwa_window_acc import apwa_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [SAMPLE_BITS-1:0]     sample,
  input  wire xing_t                      xing,
  input  wire logic [PERIOD_BITS-1:0]     periods_per_window,
  output logic                            close,
  output logic [SAMPLE_BITS+15:0]         rec_sum,
  output logic [2*SAMPLE_BITS+15:0]       rec_sum_squares,
  output logic [SAMPLE_BITS-1:0]          rec_min,
  output logic [SAMPLE_BITS-1:0]          rec_max,
  output logic [15:0]                     rec_count
);

  localparam int SW  = SAMPLE_BITS + 16;
  localparam int QW  = 2 * SAMPLE_BITS + 16;
  localparam int PW  = 2 * SAMPLE_BITS;

  logic [SW-1:0]          acc_sum;
  logic [QW-1:0]          acc_sq;
  logic [SAMPLE_BITS-1:0] acc_min;
  logic [SAMPLE_BITS-1:0] acc_max;
  logic [15:0]            acc_count;
  logic [PERIOD_BITS-1:0] period_counter;
  logic [PERIOD_BITS-1:0] period_counter_next;
  logic [SW:0]            sum_wide;
  logic [PW-1:0]          square;
  logic [QW:0]            sq_wide;
  logic                   clear;

  always_comb begin
    square    = PW'(sample) * PW'(sample);
    sum_wide  = {1'b0, acc_sum} + (SW+1)'(sample);
    sq_wide   = {1'b0, acc_sq} + (QW+1)'(square);
    rec_sum   = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
    rec_sum_squares = sq_wide[QW] ? {QW{1'b1}} : sq_wide[QW-1:0];
    rec_min   = (sample < acc_min) ? sample : acc_min;
    rec_max   = (sample > acc_max) ? sample : acc_max;
    rec_count = (acc_count == 16'hFFFF) ? acc_count : acc_count + 16'd1;
    period_counter_next = (xing.rising && period_counter != {PERIOD_BITS{1'b1}}) ?
                          period_counter + PERIOD_BITS'(1) : period_counter;
    close = xing.armed && (period_counter_next >= periods_per_window);
    clear = close || (!xing.armed && xing.rising);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sum        <= '0;
      acc_sq         <= '0;
      acc_min        <= '1;
      acc_max        <= '0;
      acc_count      <= '0;
      period_counter <= '0;
    end else if (step) begin
      if (clear) begin
        acc_sum        <= '0;
        acc_sq         <= '0;
        acc_min        <= '1;
        acc_max        <= '0;
        acc_count      <= '0;
        period_counter <= '0;
      end else if (xing.armed) begin
        acc_sum        <= rec_sum;
        acc_sq         <= rec_sum_squares;
        acc_min        <= rec_min;
        acc_max        <= rec_max;
        acc_count      <= rec_count;
        period_counter <= period_counter_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ac_period_window_accumulator_core.sv -----
// AC period window accumulator top level: input register, config registers,
// bias tracker, window accumulators and result register. Depends on apwa_pkg.
//
// Accepts one ADC sample per clock cycle, sustained; the record of a window is
// presented by the result register after the sample closing it has passed
// through the input register. The combinational bias filter update and
// crossing compare set the critical path. Input and result sides are parted by
// the result register, so samples keep flowing while a record waits; only a
// sample that closes another window is held in the input register until the
// waiting record is taken. Config writes take effect at once and are always
// accepted.
`default_nettype none

module ac_period_window_accumulator_core import apwa_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [SAMPLE_BITS-1:0]     sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [SAMPLE_BITS+15:0]         window_sum,
  output logic [2*SAMPLE_BITS+15:0]       window_sum_squares,
  output logic [SAMPLE_BITS-1:0]          window_min,
  output logic [SAMPLE_BITS-1:0]          window_max,
  output logic [15:0]                     window_count,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]   cfg_data
);

  logic [SHIFT_BITS-1:0]    bias_rate;
  logic [HYST_BITS-1:0]     hysteresis;
  logic [PERIOD_BITS-1:0]   periods_per_window;
  logic                     in_full;
  logic [SAMPLE_BITS-1:0]   in_sample;
  logic                     adv;
  xing_t                    xing;
  logic                     close;
  logic [SAMPLE_BITS+15:0]  rec_sum;
  logic [2*SAMPLE_BITS+15:0] rec_sum_squares;
  logic [SAMPLE_BITS-1:0]   rec_min;
  logic [SAMPLE_BITS-1:0]   rec_max;
  logic [15:0]              rec_count;

  assign cfg_ready = 1'b1;
  assign adv       = in_full && (!close || !out_valid || out_ready);
  assign in_ready  = !in_full || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_rate          <= SHIFT_BITS'(6);
      hysteresis         <= HYST_BITS'(8);
      periods_per_window <= PERIOD_BITS'(25);
    end else if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index))
        CFG_BIAS_RATE:  bias_rate          <= cfg_data[SHIFT_BITS-1:0];
        CFG_HYSTERESIS: hysteresis         <= cfg_data[HYST_BITS-1:0];
        CFG_PERIODS:    periods_per_window <= cfg_data[PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_sample <= sample;
    end
  end

  apwa_bias_tracker #(.SAMPLE_BITS(SAMPLE_BITS)) u_bias (
    .clk        (clk),
    .rst        (rst),
    .step       (adv),
    .sample     (in_sample),
    .bias_rate  (bias_rate),
    .hysteresis (hysteresis),
    .xing       (xing)
  );

  apwa_window_acc #(.SAMPLE_BITS(SAMPLE_BITS)) u_acc (
    .clk                (clk),
    .rst                (rst),
    .step               (adv),
    .sample             (in_sample),
    .xing               (xing),
    .periods_per_window (periods_per_window),
    .close              (close),
    .rec_sum            (rec_sum),
    .rec_sum_squares    (rec_sum_squares),
    .rec_min            (rec_min),
    .rec_max            (rec_max),
    .rec_count          (rec_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && close) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && close) begin
      window_sum         <= rec_sum;
      window_sum_squares <= rec_sum_squares;
      window_min         <= rec_min;
      window_max         <= rec_max;
      window_count       <= rec_count;
    end
  end

  a_close_armed: assert property (@(posedge clk) disable iff (rst)
    close |-> xing.armed)
    else $error("window closed while not armed");

  a_record_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_count != 16'd0) && (window_min <= window_max))
    else $error("closed window record is inconsistent");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_result_needs_sample: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_full))
    else $error("result appeared without a sample in flight");

endmodule

`default_nettype wire

// ----- tb/sv/tb_ac_period_window_accumulator_core.sv -----
// Self-checking testbench for ac_period_window_accumulator_core: directed table, random AC
// waveforms and one long full-scale window, checked word by word against a local predictor.
// Depends on apwa_pkg and the core RTL only.
module tb_ac_period_window_accumulator_core;
  import apwa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 300;
  localparam int ITEM_GOAL = 1300;
  localparam int SOAK_LEN = 40;
  localparam int DRAIN_LIMIT = 10000;
  localparam longint LIMIT_NS = 20_000_000;
  localparam longint SUM_CAP = (longint'(1) << (SB + 16)) - 1;
  localparam longint SQ_CAP = (longint'(1) << (2 * SB + 16)) - 1;
  localparam int PERIOD_CAP = 255;
  localparam int COUNT_CAP = 65535;
  localparam int FULL_SCALE = 1023;

  typedef struct packed {
    logic [SB+15:0]   sum;
    logic [2*SB+15:0] sq;
    logic [SB-1:0]    lo;
    logic [SB-1:0]    hi;
    logic [15:0]      cnt;
  } win_rec_t;

  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    cfg_reg_e      idx;
    logic [15:0]   data;
    logic [SB-1:0] smp;
    bit            typed;
    win_rec_t      want;
  } plan_row_t;

  localparam int PLAN_LEN = 29;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_WRITE,  CFG_PERIODS,    16'hFF01, 10'd0,    1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd512,  1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd0,    1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd1023, 1'b0, '0},  // arms
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd0,    1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd1023, 1'b1,
      '{26'd1023, 36'd1046529, 10'd0, 10'd1023, 16'd2}},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd1023, 1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd1023, 1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd0,    1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd1023, 1'b0, '0},
    '{ROW_WRITE,  CFG_HYSTERESIS, 16'hFE00, 10'd0,    1'b0, '0},
    '{ROW_WRITE,  CFG_PERIODS,    16'hFF00, 10'd0,    1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd512,  1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd512,  1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd700,  1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd300,  1'b0, '0},
    '{ROW_WRITE,  CFG_BIAS_RATE,  16'hFFF0, 10'd0,    1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd0,    1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd1023, 1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd1,    1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd1022, 1'b0, '0},
    '{ROW_WRITE,  CFG_BIAS_RATE,  16'h000F, 10'd0,    1'b0, '0},
    '{ROW_WRITE,  CFG_HYSTERESIS, 16'hFFFF, 10'd0,    1'b0, '0},
    '{ROW_WRITE,  CFG_PERIODS,    16'h00FF, 10'd0,    1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd0,    1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd1023, 1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd0,    1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd1023, 1'b0, '0},
    '{ROW_SAMPLE, CFG_BIAS_RATE,  16'h0000, 10'd512,  1'b0, '0}
  };

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [SB-1:0]            sample;
  logic                     out_valid;
  logic                     out_ready;
  logic [SB+15:0]           window_sum;
  logic [2*SB+15:0]         window_sum_squares;
  logic [SB-1:0]            window_min;
  logic [SB-1:0]            window_max;
  logic [15:0]              window_count;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  ac_period_window_accumulator_core #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .window_sum(window_sum), .window_sum_squares(window_sum_squares),
    .window_min(window_min), .window_max(window_max), .window_count(window_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // tracker state
  longint m_bias;
  bit     m_below, m_seen, m_armed;
  int     m_periods;
  longint m_sum, m_sq;
  int     m_lo, m_hi, m_cnt;
  int     cf_shift, cf_hyst, cf_ppw;

  win_rec_t pending_windows[$];
  int  errors, n_samples, n_windows, n_writes;
  bit  tx_idle_on, rx_idle_on, no_idle, long_hold_req;

  function automatic void open_window();
    m_sum = 0;
    m_sq = 0;
    m_lo = FULL_SCALE;
    m_hi = 0;
    m_cnt = 0;
    m_periods = 0;
  endfunction

  function automatic bit advance_tracker(input logic [SB-1:0] s, output win_rec_t rec);
    longint diff, centered;
    bit below, above, rising;
    rec = '0;
    diff = (longint'(s) <<< 8) - m_bias;
    m_bias = m_bias + (diff >>> cf_shift);
    centered = longint'(s) - (m_bias >>> 8);
    below = centered <= -longint'(cf_hyst);
    above = centered >= longint'(cf_hyst);
    rising = m_seen && m_below && above;
    if (below) m_below = 1'b1;
    else if (above) m_below = 1'b0;
    m_seen = 1'b1;
    if (!m_armed) begin
      if (rising) begin
        m_armed = 1'b1;
        open_window();
        m_below = 1'b0;
      end
      return 1'b0;
    end
    if (int'(s) < m_lo) m_lo = s;
    if (int'(s) > m_hi) m_hi = s;
    m_sum = m_sum + s;
    if (m_sum > SUM_CAP) m_sum = SUM_CAP;
    m_sq = m_sq + longint'(s) * longint'(s);
    if (m_sq > SQ_CAP) m_sq = SQ_CAP;
    if (m_cnt < COUNT_CAP) m_cnt++;
    if (rising && m_periods < PERIOD_CAP) m_periods++;
    if (m_periods >= cf_ppw) begin
      rec.sum = m_sum[SB+15:0];
      rec.sq = m_sq[2*SB+15:0];
      rec.lo = m_lo[SB-1:0];
      rec.hi = m_hi[SB-1:0];
      rec.cnt = m_cnt[15:0];
      open_window();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [SB-1:0] wave_point(int i, int per, int amp, int ctr, int shape,
                                               int jit);
    int frac, off, v;
    frac = ((i % per) * 1024) / per;
    case (shape)
      0: off = (((frac < 512) ? frac * 2 : (1023 - frac) * 2) - 511) * amp / 511;
      1: off = (frac < 512) ? -amp : amp;
      default: off = (frac - 512) * amp / 512;
    endcase
    v = ctr + off;
    if (jit > 0) v = v + int'($urandom_range(0, 2 * jit)) - jit;
    if (v < 0) v = 0;
    if (v > FULL_SCALE) v = FULL_SCALE;
    return v[SB-1:0];
  endfunction

  task automatic note_mismatch(input string msg);
    errors++;
    $display("[%0t] error: %s", $time, msg);
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] d);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do begin
      @(negedge clk);
      took = (cfg_ready === 1'b1);
      @(posedge clk);
    end while (!took);
    n_writes++;
    case (idx)
      CFG_BIAS_RATE:  cf_shift = d[SHIFT_BITS-1:0];
      CFG_HYSTERESIS: cf_hyst = d[HYST_BITS-1:0];
      CFG_PERIODS:    cf_ppw = d[PERIOD_BITS-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_sample(input logic [SB-1:0] s, input bit typed, input win_rec_t want);
    bit took;
    bit closes;
    win_rec_t rec;
    if (tx_idle_on && !no_idle && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do begin
      @(negedge clk);
      took = (in_ready === 1'b1);
      @(posedge clk);
    end while (!took);
    n_samples++;
    closes = advance_tracker(s, rec);
    if (typed) pending_windows.push_back(want);
    else if (closes) pending_windows.push_back(rec);
  endtask

  // all records in, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout: words stopped moving");
    $display("simulation failed");
    $finish;
  end

  initial begin : rx_drive
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (rx_idle_on && !no_idle && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin : rx_check
    win_rec_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_windows.size() == 0) begin
        note_mismatch("window record with none pending");
      end else begin
        want = pending_windows.pop_front();
        n_windows++;
        cmp_field("window_sum", 64'(window_sum), 64'(want.sum));
        cmp_field("window_sum_squares", 64'(window_sum_squares), 64'(want.sq));
        cmp_field("window_min", 64'(window_min), 64'(want.lo));
        cmp_field("window_max", 64'(window_max), 64'(want.hi));
        cmp_field("window_count", 64'(window_count), 64'(want.cnt));
      end
    end
  end

  initial begin : stim
    int i, len, per, amp, ctr, shape, jit, noise, pause_at, pick, guard;
    logic [SB-1:0] v;
    logic [15:0] d;
    errors = 0;
    n_samples = 0;
    n_windows = 0;
    n_writes = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    no_idle = 1'b0;
    long_hold_req = 1'b0;
    cf_shift = 6;
    cf_hyst = 8;
    cf_ppw = 25;
    m_bias = longint'(512) <<< 8;
    m_below = 1'b0;
    m_seen = 1'b0;
    m_armed = 1'b0;
    open_window();
    rst <= 1'b1;
    in_valid <= 1'b0;
    sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BIAS_RATE;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        settle();
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        push_sample(PLAN[i].smp, PLAN[i].typed, PLAN[i].want);
      end
    end

    // output held off while every armed sample closes a window: input must back up
    settle();
    write_reg(CFG_BIAS_RATE, 16'd3);
    write_reg(CFG_HYSTERESIS, 16'd8);
    write_reg(CFG_PERIODS, 16'd0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (i = 0; i < 80; i++) begin
      if (i == 20) long_hold_req = 1'b1;
      push_sample(wave_point(i, 8, 400, 512, 1, 0), 1'b0, '0);
    end

    while (n_samples < ITEM_GOAL) begin
      settle();
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0: pick = 0;
          1: pick = 15;
          default: pick = $urandom_range(1, 8);
        endcase
        d = 16'($urandom());
        d[SHIFT_BITS-1:0] = SHIFT_BITS'(pick);
        write_reg(CFG_BIAS_RATE, d);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0: pick = 0;
          1: pick = 511;
          2: pick = $urandom_range(0, 511);
          default: pick = $urandom_range(0, 40);
        endcase
        d = 16'($urandom());
        d[HYST_BITS-1:0] = HYST_BITS'(pick);
        write_reg(CFG_HYSTERESIS, d);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: pick = 0;
          1: pick = 255;
          default: pick = $urandom_range(1, 4);
        endcase
        d = 16'($urandom());
        d[PERIOD_BITS-1:0] = PERIOD_BITS'(pick);
        write_reg(CFG_PERIODS, d);
      end
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      len = $urandom_range(60, 180);
      per = $urandom_range(4, 40);
      amp = $urandom_range(40, 511);
      ctr = $urandom_range(300, 723);
      shape = $urandom_range(0, 2);
      jit = $urandom_range(0, 8);
      noise = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(0, 15);
      pause_at = ($urandom_range(0, 3) == 0) ? len / 2 : -1;
      for (i = 0; i < len; i++) begin
        if (i == pause_at) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_windows.size() != 0);
        end
        if ($urandom_range(0, 99) < noise) v = SB'($urandom_range(0, FULL_SCALE));
        else v = wave_point(i, per, amp, ctr, shape, jit);
        push_sample(v, 1'b0, '0);
      end
    end

    // long window held at full scale, no idling on either side
    settle();
    no_idle = 1'b1;
    write_reg(CFG_BIAS_RATE, 16'd1);
    write_reg(CFG_HYSTERESIS, 16'd8);
    write_reg(CFG_PERIODS, 16'd1);
    for (i = 0; i < 20; i++) push_sample(SB'(512), 1'b0, '0);
    push_sample(SB'(0), 1'b0, '0);
    push_sample(SB'(FULL_SCALE), 1'b0, '0);
    for (i = 0; i < SOAK_LEN; i++) push_sample(SB'(FULL_SCALE), 1'b0, '0);
    push_sample(SB'(0), 1'b0, '0);
    push_sample(SB'(FULL_SCALE), 1'b0, '0);

    in_valid <= 1'b0;
    guard = 0;
    while (pending_windows.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_windows.size() != 0)
      note_mismatch($sformatf("%0d window records never arrived", pending_windows.size()));
    $display("covered %0d samples, %0d window records, %0d register writes",
             n_samples, n_windows, n_writes);
    $display("incl. zero hysteresis/shift/periods, register extremes, output hold, full scale");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- ac_period_window_accumulator_core.f -----
rtl/apwa_pkg.sv
rtl/apwa_bias_tracker.sv
rtl/apwa_window_acc.sv
rtl/ac_period_window_accumulator_core.sv
tb/sv/tb_ac_period_window_accumulator_core.sv
